// ----- sv/efd_pkg.sv -----
package efd_pkg;

  localparam int LEN_BITS  = 18;
  localparam int MAX_W     = 18;
  localparam int FLEN_W    = 18;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = (LEN_BITS > MAX_W) ? LEN_BITS : MAX_W;

  localparam logic [7:0] SYM_START = 8'hAC;
  localparam logic [7:0] SYM_END   = 8'hAD;
  localparam logic [7:0] SYM_ESC   = 8'hAE;
  localparam logic [7:0] ESC_FLIP  = 8'h80;

  localparam logic [7:0]       CRC_POLY_RST = 8'h07;
  localparam logic [7:0]       CRC_INIT_RST = 8'h00;
  localparam logic [MAX_W-1:0] MAX_FRAME_RST = MAX_W'(1024 * 128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRC_POLY  = 2'd0,
    REG_CRC_INIT  = 2'd1,
    REG_MAX_FRAME = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  // Contents of the input register handed to the decoder.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stg_t;

  // One byte through an MSB-first CRC-8 with implicit x^8 term.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/efd_in_if.sv -----
interface efd_in_if;
  import efd_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- sv/efd_out_if.sv -----
interface efd_out_if;
  import efd_pkg::*;

  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [7:0]        out_data;
  logic [FLEN_W-1:0] frame_len;

  modport source (output valid, output kind, output out_data, output frame_len, input ready);
  modport sink   (input valid, input kind, input out_data, input frame_len, output ready);
endinterface

// ----- sv/efd_in_reg.sv -----
module efd_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  efd_in_if.sink          in_if,
  input  logic            adv,
  output efd_pkg::stg_t   stg
);
  import efd_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       take;

  // The register frees up in the same cycle the decoder consumes it.
  assign in_if.ready = !valid_r || adv;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_if.in_byte;
    end
  end

  assign stg.valid = valid_r;
  assign stg.data  = data_r;

endmodule

// ----- sv/efd_core.sv -----
module efd_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  efd_pkg::stg_t                  stg,
  output logic                           adv,
  efd_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [efd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [efd_pkg::CFG_W-1:0]      cfg_wdata
);
  import efd_pkg::*;

  typedef enum logic [1:0] {
    M_HUNT  = 2'd0,
    M_FRAME = 2'd1,
    M_ESC   = 2'd2,
    M_PEND  = 2'd3
  } mode_t;

  logic [7:0]       poly_r;
  logic [7:0]       init_r;
  logic [MAX_W-1:0] max_r;

  mode_t               mode_r, mode_nxt;
  logic                hv_r, hv_nxt;
  logic [7:0]          held_r, held_nxt;
  logic [7:0]          crc_r, crc_nxt;
  logic [LEN_BITS-1:0] cnt_r, cnt_nxt;

  logic              out_v_r;
  kind_t             out_kind_r;
  logic [7:0]        out_data_r;
  logic [FLEN_W-1:0] out_len_r;

  logic              res_v;
  kind_t             res_kind;
  logic [7:0]        res_data;
  logic [FLEN_W-1:0] res_len;

  logic [7:0]          b;
  logic [7:0]          tb;
  logic                over;
  logic [LEN_BITS-1:0] cnt_inc;
  logic [LEN_BITS-1:0] emit_cnt;
  logic [FLEN_W-1:0]   emit_len;
  logic [7:0]          crc_upd;
  logic                good_now;
  logic                good_esc;

  assign b        = stg.data;
  assign tb       = (mode_r == M_ESC) ? (stg.data ^ ESC_FLIP) : stg.data;
  assign over     = (CMP_W'(cnt_r) >= CMP_W'(max_r)) || (&cnt_r);
  assign cnt_inc  = cnt_r + LEN_BITS'(1);
  assign emit_cnt = (cnt_r == '0) ? '0 : cnt_r - LEN_BITS'(1);
  assign emit_len = FLEN_W'(emit_cnt);
  assign crc_upd  = crc8_step(crc_r, held_r, poly_r);
  assign good_now = (cnt_r >= LEN_BITS'(2)) && (held_r == crc_r);
  // Escape-then-end closes right after the escaped byte is taken in.
  assign good_esc = (cnt_inc >= LEN_BITS'(2)) && (tb == (hv_r ? crc_upd : crc_r));

  always_comb begin
    mode_nxt = mode_r;
    hv_nxt   = hv_r;
    held_nxt = held_r;
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    res_v    = 1'b0;
    res_kind = KIND_PAYLOAD;
    res_data = '0;
    res_len  = '0;

    unique case (mode_r)
      M_HUNT, M_PEND: begin
        if (mode_r == M_PEND) begin
          res_v    = 1'b1;
          res_kind = good_now ? KIND_GOOD : KIND_BAD;
          res_len  = emit_len;
          hv_nxt   = 1'b0;
        end
        if (b == SYM_START) begin
          mode_nxt = M_FRAME;
          crc_nxt  = init_r;
          hv_nxt   = 1'b0;
          held_nxt = '0;
          cnt_nxt  = '0;
        end else begin
          mode_nxt = M_HUNT;
        end
      end
      M_FRAME, M_ESC: begin
        if (mode_r == M_FRAME && b == SYM_START) begin
          mode_nxt = M_FRAME;
        end else if (mode_r == M_FRAME && b == SYM_END) begin
          res_v    = 1'b1;
          res_kind = good_now ? KIND_GOOD : KIND_BAD;
          res_len  = emit_len;
          mode_nxt = M_HUNT;
          hv_nxt   = 1'b0;
        end else if (mode_r == M_FRAME && b == SYM_ESC) begin
          mode_nxt = M_ESC;
        end else if (over) begin
          // Frame too long: the held byte is dropped with a bad verdict.
          res_v    = 1'b1;
          res_kind = KIND_BAD;
          res_len  = emit_len;
          mode_nxt = M_HUNT;
          hv_nxt   = 1'b0;
        end else begin
          mode_nxt = M_FRAME;
          cnt_nxt  = cnt_inc;
          held_nxt = tb;
          hv_nxt   = 1'b1;
          if (hv_r) begin
            crc_nxt  = crc_upd;
            res_v    = 1'b1;
            res_kind = KIND_PAYLOAD;
            res_data = held_r;
          end
          if (mode_r == M_ESC && b == SYM_END) begin
            if (hv_r) begin
              // The payload byte goes out now; the verdict follows with the next byte.
              mode_nxt = M_PEND;
            end else begin
              res_v    = 1'b1;
              res_kind = good_esc ? KIND_GOOD : KIND_BAD;
              res_len  = FLEN_W'(cnt_r);
              mode_nxt = M_HUNT;
              hv_nxt   = 1'b0;
            end
          end
        end
      end
      default: begin
        mode_nxt = M_HUNT;
      end
    endcase
  end

  assign adv = stg.valid && (!out_v_r || out_if.ready || !res_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r     <= CRC_POLY_RST;
      init_r     <= CRC_INIT_RST;
      max_r      <= MAX_FRAME_RST;
      mode_r     <= M_HUNT;
      hv_r       <= 1'b0;
      held_r     <= '0;
      crc_r      <= CRC_INIT_RST;
      cnt_r      <= '0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_CRC_POLY:  poly_r <= cfg_wdata[7:0];
          REG_CRC_INIT:  init_r <= cfg_wdata[7:0];
          REG_MAX_FRAME: max_r  <= cfg_wdata[MAX_W-1:0];
          default: begin
          end
        endcase
      end
      if (adv) begin
        mode_r <= mode_nxt;
        hv_r   <= hv_nxt;
        held_r <= held_nxt;
        crc_r  <= crc_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (adv && res_v) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_v) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_len_r  <= res_len;
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.kind      = out_kind_r;
  assign out_if.out_data  = out_data_r;
  assign out_if.frame_len = out_len_r;

endmodule

// ----- sv/escaped_frame_decoder_crc8_top.sv -----
// Byte-stuffed frame decoder with CRC-8 check. One line byte transfers in per cycle when the
// result side keeps up; a byte is decoded against the frame state from the input register,
// and the result it causes is offered from the output register. Bytes that cause
// no result never wait; a byte that causes a result waits only while the output register
// still holds an earlier result that has not been transferred. Before a start byte 0xAC all
// bytes are dropped; inside a frame 0xAE escapes the next byte (XOR 0x80), 0xAD closes the
// frame, and payload bytes come out one byte late so the trailing CRC byte is never emitted.
// Each frame ends with a good or bad verdict carrying the payload length. Registers: 0 CRC
// polynomial, 1 CRC start value, 2 maximum decoded frame length; write them only while idle.
module escaped_frame_decoder_crc8_top (
  input  logic                           clk,
  input  logic                           rst_n,
  efd_in_if.sink                         in_if,
  efd_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [efd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [efd_pkg::CFG_W-1:0]      cfg_wdata
);
  import efd_pkg::*;

  stg_t stg;
  logic adv;

  efd_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .adv   (adv),
    .stg   (stg)
  );

  efd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg       (stg),
    .adv       (adv),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ----- sv/efd_checker.sv -----
module efd_checker (
  input logic       clk,
  input logic       rst_n,
  efd_in_if.sink    in_if,
  efd_out_if.source out_if
);
  import efd_pkg::*;

  // A held result stays put until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.kind) &&
    $stable(out_if.out_data) && $stable(out_if.frame_len))
    else $error("result changed while stalled");

  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.kind == KIND_PAYLOAD && out_if.frame_len == '0) ||
    ((out_if.kind == KIND_GOOD || out_if.kind == KIND_BAD) && out_if.out_data == '0))
    else $error("result fields inconsistent with kind");

  // A fresh result is always caused by a byte transferred earlier through the input register.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(in_if.valid && in_if.ready, 2))
    else $error("result without a matching input transfer");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid right after reset");

endmodule

bind escaped_frame_decoder_crc8_top efd_checker u_efd_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);

// ----- dv/efd_tb_pkg.sv -----
package efd_tb_pkg;

  // MSB-first CRC-8, one data bit at a time, implicit x^8 term.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

endpackage

// ----- dv/efd_decode_checker.sv -----
module efd_decode_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [7:0]                        in_byte,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  efd_pkg::kind_t                    out_kind,
  input  logic [7:0]                        out_data,
  input  logic [efd_pkg::FLEN_W-1:0]        out_len,
  input  logic                              cfg_we,
  input  logic [efd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [efd_pkg::CFG_W-1:0]         cfg_wdata,
  output int                                errors,
  output int                                pending,
  output int                                checked
);
  import efd_pkg::*;

  typedef enum logic [1:0] {
    DEC_HUNT,
    DEC_FRAME,
    DEC_ESC,
    DEC_PEND
  } dec_mode_t;

  typedef struct {
    kind_t             kind;
    logic [7:0]        data;
    logic [FLEN_W-1:0] len;
  } frame_result_t;

  localparam logic [LEN_BITS-1:0] COUNT_FULL = '1;

  logic [7:0]          poly;
  logic [7:0]          init_val;
  logic [MAX_W-1:0]    max_len;
  dec_mode_t           mode;
  logic                held_valid;
  logic [7:0]          held_byte;
  logic [7:0]          crc;
  logic [LEN_BITS-1:0] count;
  frame_result_t       pending_results[$];

  // The held byte is the CRC, so it never counts as payload.
  function automatic logic [FLEN_W-1:0] payload_len();
    return (count == 0) ? '0 : FLEN_W'(count - 1);
  endfunction

  task automatic report(input string msg);
    $display("checker: %s", msg);
    errors++;
  endtask

  task automatic expect_result(input kind_t k, input logic [7:0] d,
                               input logic [FLEN_W-1:0] l);
    frame_result_t r;
    r.kind = k;
    r.data = d;
    r.len  = l;
    pending_results = {pending_results, r};
  endtask

  task automatic close_frame();
    logic good;
    good = (count >= 2) && (held_byte == crc);
    expect_result(good ? KIND_GOOD : KIND_BAD, 8'h00, payload_len());
    mode = DEC_HUNT;
    held_valid = 1'b0;
  endtask

  task automatic open_if_start(input logic [7:0] b);
    if (b == SYM_START) begin
      mode = DEC_FRAME;
      crc = init_val;
      held_valid = 1'b0;
      held_byte = 8'h00;
      count = '0;
    end else begin
      mode = DEC_HUNT;
    end
  endtask

  task automatic take_decoded(input logic [7:0] b, output bit emitted);
    logic [7:0] prev;
    bit         had;
    prev = held_byte;
    had = held_valid;
    emitted = 1'b0;
    if (count >= max_len || count == COUNT_FULL) begin
      expect_result(KIND_BAD, 8'h00, payload_len());
      mode = DEC_HUNT;
      held_valid = 1'b0;
    end else begin
      count = count + 1'b1;
      held_byte = b;
      held_valid = 1'b1;
      if (had) begin
        crc = efd_tb_pkg::crc8_next(crc, prev, poly);
        emitted = 1'b1;
        expect_result(KIND_PAYLOAD, prev, '0);
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    bit em;
    case (mode)
      DEC_HUNT: open_if_start(b);
      DEC_PEND: begin
        close_frame();
        open_if_start(b);
      end
      DEC_FRAME: begin
        // A start byte inside a frame is skipped.
        if (b == SYM_END) close_frame();
        else if (b == SYM_ESC) mode = DEC_ESC;
        else if (b != SYM_START) take_decoded(b, em);
      end
      DEC_ESC: begin
        mode = DEC_FRAME;
        take_decoded(b ^ ESC_FLIP, em);
        // An escaped end byte is data and a close at once. When it pushed out a payload
        // byte, the verdict waits for the next line byte.
        if (b == SYM_END && mode != DEC_HUNT) begin
          if (em) mode = DEC_PEND;
          else close_frame();
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      poly = CRC_POLY_RST;
      init_val = CRC_INIT_RST;
      max_len = MAX_FRAME_RST;
      mode = DEC_HUNT;
      held_valid = 1'b0;
      held_byte = 8'h00;
      crc = CRC_INIT_RST;
      count = '0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        checked++;
        if (pending_results.size() == 0) begin
          report($sformatf("result with nothing expected: kind %0d data 0x%02h len %0d",
                           out_kind, out_data, out_len));
        end else begin
          want = pending_results.pop_front();
          if (out_kind !== want.kind)
            report($sformatf("kind mismatch, got %0d expected %0d", out_kind, want.kind));
          if (out_data !== want.data)
            report($sformatf("out_data mismatch, got 0x%02h expected 0x%02h",
                             out_data, want.data));
          if (out_len !== want.len)
            report($sformatf("frame_len mismatch, got %0d expected %0d", out_len, want.len));
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_CRC_POLY:  poly = cfg_wdata[7:0];
          REG_CRC_INIT:  init_val = cfg_wdata[7:0];
          REG_MAX_FRAME: max_len = cfg_wdata[MAX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        decode_byte(in_byte);
      end
    end
    pending = pending_results.size();
  end

endmodule

// ----- dv/testbench.sv -----
module testbench;
  import efd_pkg::*;

  typedef logic [7:0] line_bytes_t[$];

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  // What an escaped end byte decodes to.
  localparam logic [7:0] ESC_END_DATA = SYM_END ^ ESC_FLIP;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  efd_in_if  in_ch();
  efd_out_if out_ch();

  int errors;
  int pending;
  int checked;
  int cycles = 0;
  int frames = 0;
  int body_bytes = 0;
  int sent = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  bit holding = 1'b0;
  bit tx_gaps = 1'b1;

  // Register values as written, needed to build frames with a correct CRC.
  logic [7:0] poly_now = CRC_POLY_RST;
  logic [7:0] init_now = CRC_INIT_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  escaped_frame_decoder_crc8_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  efd_decode_checker decode_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.in_byte),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_data  (out_ch.out_data),
    .out_len   (out_ch.frame_len),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: cycle limit hit with %0d results outstanding", pending);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 90);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
    gap = tx_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_seq(input line_bytes_t s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // Escaping an ordinary byte is legal, except that an escaped end byte closes the frame.
  task automatic send_encoded(input logic [7:0] b, input bit esc_any);
    if (b == SYM_START || b == SYM_END || b == SYM_ESC || (esc_any && b != ESC_END_DATA)) begin
      send_byte(SYM_ESC);
      send_byte(b ^ ESC_FLIP);
    end else begin
      send_byte(b);
    end
  endtask

  function automatic logic [7:0] crc_of(input line_bytes_t body);
    logic [7:0] c;
    c = init_now;
    foreach (body[i]) c = efd_tb_pkg::crc8_next(c, body[i], poly_now);
    return c;
  endfunction

  task automatic send_frame(input line_bytes_t body, input bit corrupt, input bit closing_escape);
    logic [7:0] tail;
    bit         esc_any;
    esc_any = ($urandom_range(0, 3) == 0);
    tail = crc_of(body);
    if (corrupt) tail = tail ^ 8'($urandom_range(1, 255));
    send_byte(SYM_START);
    foreach (body[i]) begin
      if ($urandom_range(0, 19) == 0) send_byte(SYM_START);
      send_encoded(body[i], esc_any);
    end
    if (closing_escape) begin
      send_byte(SYM_ESC);
      send_byte(SYM_END);
    end else begin
      send_encoded(tail, esc_any);
      send_byte(SYM_END);
    end
    frames++;
    body_bytes += body.size();
  endtask

  function automatic line_bytes_t rand_body(input int longest);
    line_bytes_t q;
    int          n;
    logic [7:0]  pick;
    n = $urandom_range(0, longest);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: pick = SYM_START;
        1: pick = SYM_END;
        2: pick = SYM_ESC;
        3: pick = ESC_END_DATA;
        default: pick = 8'($urandom);
      endcase
      q = {q, pick};
    end
    return q;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_CRC_POLY: poly_now = val[7:0];
      REG_CRC_INIT: init_now = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] poly, input logic [7:0] init,
                           input logic [MAX_W-1:0] max_bytes);
    wait_drained();
    write_reg(REG_CRC_POLY, CFG_W'(poly));
    write_reg(REG_CRC_INIT, CFG_W'(init));
    write_reg(REG_MAX_FRAME, CFG_W'(max_bytes));
  endtask

  // The budget is counted in line bytes transferred.
  task automatic run_traffic(input int budget, input int longest);
    int          start;
    int          r;
    line_bytes_t body;
    start = sent;
    while (sent - start < budget) begin
      r = $urandom_range(0, 99);
      body = rand_body(longest);
      if (r < 70) begin
        send_frame(body, $urandom_range(0, 6) == 0, 1'b0);
      end else if (r < 78) begin
        send_frame(body, 1'b0, 1'b1);
      end else if (r < 88) begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(($urandom_range(0, 2) == 0) ? SYM_END : 8'($urandom));
        end
      end else if (r < 95) begin
        // Cut-off frame: the next start byte is skipped, so it runs into the next frame.
        send_byte(SYM_START);
        foreach (body[i]) send_encoded(body[i], 1'b0);
      end else begin
        wait_drained();
      end
    end
  endtask

  // Stall the result side for a long time while the sender keeps offering a long frame.
  task automatic overfill();
    line_bytes_t body;
    in_ch.valid <= 1'b0;
    hold_reqs++;
    wait (holding);
    @(negedge clk);
    repeat (80) body = {body, 8'($urandom)};
    tx_gaps = 1'b0;
    send_frame(body, 1'b0, 1'b0);
    tx_gaps = 1'b1;
  endtask

  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_served < hold_reqs) begin
        hold_served++;
        holding = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding = 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
        g = idle_len();
        if (g > 0) begin
          out_ch.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
    end
  end

  initial begin
    line_bytes_t seq;
    logic [7:0]  tail;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Stray bytes before any start, including an end byte, are dropped.
    seq = {SYM_END, 8'h00, 8'hFF};
    send_seq(seq);
    seq = {8'h00, 8'hFF};
    send_frame(seq, 1'b0, 1'b0);
    // Escape-escape and escape-start are data; a bare start inside the frame is skipped.
    seq = {8'h2E, 8'h2C};
    tail = crc_of(seq);
    seq = {SYM_START, SYM_ESC, SYM_ESC, SYM_START, SYM_ESC, SYM_START};
    send_seq(seq);
    send_encoded(tail, 1'b0);
    send_byte(SYM_END);
    // Only one decoded byte: bad.
    seq = {SYM_START, 8'h55, SYM_END};
    send_seq(seq);
    // Escaped end after a held byte: the verdict comes with the next start byte, and the
    // frame that start opens closes at once on an escaped end with nothing held.
    seq = {8'h11};
    send_frame(seq, 1'b0, 1'b1);
    seq = {SYM_START, SYM_ESC, SYM_END};
    send_seq(seq);

    run_traffic(160, 12);
    overfill();
    run_traffic(80, 12);

    configure(8'hFF, 8'hFF, MAX_W'(2));
    seq = {8'h01};
    send_frame(seq, 1'b0, 1'b0);
    seq = {8'h01, 8'h02, 8'h03};
    send_frame(seq, 1'b0, 1'b0);
    run_traffic(100, 4);

    configure(8'h00, 8'h00, MAX_W'(131072));
    run_traffic(140, 16);

    configure(8'($urandom), 8'($urandom), MAX_W'($urandom_range(3, 40)));
    run_traffic(140, 30);

    configure(8'($urandom), 8'($urandom), MAX_W'($urandom_range(2, 300)));
    run_traffic(130, 20);

    wait_drained();
    $display("testbench: %0d frames with %0d payload bytes under five register settings",
             frames, body_bytes);
    $display("testbench: %0d line bytes sent, %0d results compared, %0d mismatches",
             sent, checked, errors);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
